/* hw/rtl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sequential list engine
// Opcodes, status codes, sequencer states and the command and result beats.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int DefDepth = 256;
	localparam int DefWidth = 32;
	localparam int PosW     = 9;
	localparam int ValW     = 32;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_FIND       = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DN,
		S_FIND
	} state_t;

	typedef struct packed {
		op_t                   op;
		logic [PosW-1:0]       position;
		logic signed [ValW-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t         status;
		logic [PosW-1:0] found_position;
		logic [PosW-1:0] count;
	} res_t;

endpackage

/* hw/rtl/sequential_list_engine.sv */
// ----------------------------------------------------------------------------
// sequential_list_engine: packed array list with insert, erase and find
// Fixed-depth list held in a single-port-write, single-port-read memory.
// ----------------------------------------------------------------------------
// Usage
//   A command beat (cmd) is taken at a rising edge with start high and busy
//   low. Each command yields exactly one result beat on result, marked by a
//   one-cycle strobe in the cycle after the command completes. The receiver
//   cannot stall; every result must be taken in its strobe cycle.
// Timing
//   Push back, pop back, rejected commands and commands needing no move
//   complete at the accept edge: strobe follows in the next cycle and busy
//   stays low, so such commands may be issued every cycle.
//   Push front and insert move n entries up, then write the new entry.
//   Pop front and erase move n entries down.
//   Find scans one entry per cycle until a match or the last entry.
//   The worst case is set by the one read and one write port of the memory,
//   one entry moved or compared per cycle.
// Reset
//   arst_n clears the element count and the sequencer; memory contents are
//   left as they are, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine
	import sle_pkg::*;
#(
	parameter int DEPTH = DefDepth,
	parameter int WIDTH = DefWidth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic strobe,
	output res_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > PosW) ? CW : PosW;

	state_t state_q, state_d;

	logic [CW-1:0]    fill_q, fill_d;
	logic [AW-1:0]    src_q, src_d;
	logic [AW-1:0]    at_q, at_d;
	logic [WIDTH-1:0] val_q, val_d;
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] mem_q [DEPTH];

	logic             we, re, fin;
	logic [AW-1:0]    wa, ra;
	logic [WIDTH-1:0] wd;
	status_t          st_d;
	logic [PosW-1:0]  fnd_d;
	res_t             result_q;
	logic             strobe_q;

	logic             accept, full, empty, pos_gt_fill, pos_eq_fill, pos_eq_last;
	logic [CW-1:0]    fill_m1;
	logic [PW-1:0]    pos_ext;
	logic [AW-1:0]    last, pos_a;
	logic [WIDTH-1:0] val_w;
	logic             match, src_at_last;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign full        = (fill_q == CW'(DEPTH));
	assign empty       = (fill_q == '0);
	assign fill_m1     = fill_q - CW'(1);
	assign last        = fill_m1[AW-1:0];
	assign pos_ext     = PW'(cmd.position);
	assign pos_a       = pos_ext[AW-1:0];
	assign pos_gt_fill = (pos_ext > PW'(fill_q));
	assign pos_eq_fill = (pos_ext == PW'(fill_q));
	assign pos_eq_last = (pos_ext == PW'(fill_m1));
	assign val_w       = WIDTH'($unsigned(cmd.value));
	assign match       = (rd_q == val_q);
	assign src_at_last = (src_q == last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						OP_PUSH_FRONT: begin
							if (!full && !empty) state_d = S_SHIFT_UP;
						end
						OP_INSERT: begin
							if (!full && !pos_gt_fill && !pos_eq_fill) state_d = S_SHIFT_UP;
						end
						OP_POP_FRONT: begin
							if (!empty && fill_m1 != '0) state_d = S_SHIFT_DN;
						end
						OP_ERASE: begin
							if (!empty && !pos_gt_fill && !pos_eq_fill && !pos_eq_last)
								state_d = S_SHIFT_DN;
						end
						OP_FIND: begin
							if (!empty) state_d = S_FIND;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SHIFT_UP: begin
				if (src_q == at_q) state_d = S_PUT;
			end
			S_PUT:      state_d = S_IDLE;
			S_SHIFT_DN: begin
				if (src_at_last) state_d = S_IDLE;
			end
			S_FIND: begin
				if (match || src_at_last) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port control and result
	always_comb begin
		we     = 1'b0;
		wa     = '0;
		wd     = val_q;
		re     = 1'b0;
		ra     = '0;
		fin    = 1'b0;
		st_d   = ST_OK;
		fnd_d  = '0;
		fill_d = fill_q;
		src_d  = src_q;
		at_d   = at_q;
		val_d  = val_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_d = val_w;
					unique case (cmd.op)
						OP_PUSH_BACK: begin
							fin = 1'b1;
							if (full) begin
								st_d = ST_FULL;
							end else begin
								we     = 1'b1;
								wa     = fill_q[AW-1:0];
								wd     = val_w;
								fill_d = fill_q + CW'(1);
							end
						end
						OP_PUSH_FRONT: begin
							if (full) begin
								fin  = 1'b1;
								st_d = ST_FULL;
							end else if (empty) begin
								fin    = 1'b1;
								we     = 1'b1;
								wa     = '0;
								wd     = val_w;
								fill_d = fill_q + CW'(1);
							end else begin
								re    = 1'b1;
								ra    = last;
								src_d = last;
								at_d  = '0;
							end
						end
						OP_POP_BACK: begin
							fin = 1'b1;
							if (empty) st_d = ST_EMPTY;
							else fill_d = fill_m1;
						end
						OP_POP_FRONT: begin
							if (empty) begin
								fin  = 1'b1;
								st_d = ST_EMPTY;
							end else if (fill_m1 == '0) begin
								fin    = 1'b1;
								fill_d = fill_m1;
							end else begin
								re    = 1'b1;
								ra    = AW'(1);
								src_d = AW'(1);
							end
						end
						OP_INSERT: begin
							if (full) begin
								fin  = 1'b1;
								st_d = ST_FULL;
							end else if (pos_gt_fill) begin
								fin  = 1'b1;
								st_d = ST_BADPOS;
							end else if (pos_eq_fill) begin
								fin    = 1'b1;
								we     = 1'b1;
								wa     = fill_q[AW-1:0];
								wd     = val_w;
								fill_d = fill_q + CW'(1);
							end else begin
								re    = 1'b1;
								ra    = last;
								src_d = last;
								at_d  = pos_a;
							end
						end
						OP_ERASE: begin
							if (empty) begin
								fin  = 1'b1;
								st_d = ST_EMPTY;
							end else if (pos_gt_fill || pos_eq_fill) begin
								fin  = 1'b1;
								st_d = ST_BADPOS;
							end else if (pos_eq_last) begin
								fin    = 1'b1;
								fill_d = fill_m1;
							end else begin
								re    = 1'b1;
								ra    = pos_a + AW'(1);
								src_d = pos_a + AW'(1);
							end
						end
						OP_FIND: begin
							if (empty) begin
								fin  = 1'b1;
								st_d = ST_NOTFOUND;
							end else begin
								re    = 1'b1;
								ra    = '0;
								src_d = '0;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_SHIFT_UP: begin
				// write the entry read last cycle one slot up, read the next one below
				we = 1'b1;
				wa = src_q + AW'(1);
				wd = rd_q;
				if (src_q != at_q) begin
					re    = 1'b1;
					ra    = src_q - AW'(1);
					src_d = src_q - AW'(1);
				end
			end
			S_PUT: begin
				we     = 1'b1;
				wa     = at_q;
				wd     = val_q;
				fill_d = fill_q + CW'(1);
				fin    = 1'b1;
			end
			S_SHIFT_DN: begin
				we = 1'b1;
				wa = src_q - AW'(1);
				wd = rd_q;
				if (src_at_last) begin
					fill_d = fill_m1;
					fin    = 1'b1;
				end else begin
					re    = 1'b1;
					ra    = src_q + AW'(1);
					src_d = src_q + AW'(1);
				end
			end
			S_FIND: begin
				if (match) begin
					fin   = 1'b1;
					fnd_d = PosW'(src_q) + PosW'(1);
				end else if (src_at_last) begin
					fin  = 1'b1;
					st_d = ST_NOTFOUND;
				end else begin
					re    = 1'b1;
					ra    = src_q + AW'(1);
					src_d = src_q + AW'(1);
				end
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			strobe_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		src_q <= src_d;
		at_q  <= at_d;
		val_q <= val_d;
		if (fin) begin
			result_q.status         <= st_d;
			result_q.found_position <= fnd_d;
			result_q.count          <= PosW'(fill_d);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		if (re) rd_q <= mem_q[ra];
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("element count beyond depth");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.count == PosW'(fill_q))
		else $error("result count differs from stored count");

	a_grow_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_UP || state_q == S_PUT) |-> !full)
		else $error("shift up started on a full list");

	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("command finished without a result beat");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND || state_q == S_SHIFT_DN) |-> (!empty && src_q <= last))
		else $error("scan index beyond last entry");

endmodule

/* dv/tb_sequential_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine: self-checking bench for the list engine
// Drives command beats with random gaps and predicts every result beat from
// a software copy of the list. Each strobed beat is checked field by field
// against the oldest prediction. The random phase grows the list to full,
// lingers there, then drains it again, so that the full boundary and shifts
// across the whole depth are exercised.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine
	import sle_pkg::*;
;

	localparam logic [2:0] OP_UNDEFINED = 3'd7;
	localparam int         RandomItems  = 575;
	localparam int         IdlePercent  = 28;
	localparam int         LimitCycles  = 1000000;

	// Predicts result beats from a private copy of the list.
	class list_scoreboard;
		logic [DefWidth-1:0] entries [DefDepth];
		int unsigned         occupancy;
		res_t                expected_results [$];
		int                  errors;

		function new();
			occupancy = 0;
			errors    = 0;
		endfunction

		// Move entries [at, occupancy) one slot up.
		function void open_slot(int unsigned at);
			for (int unsigned k = occupancy; k > at; k--)
				entries[k] = entries[k - 1];
		endfunction

		// Move entries (at, occupancy) one slot down.
		function void close_slot(int unsigned at);
			for (int unsigned k = at + 1; k < occupancy; k++)
				entries[k - 1] = entries[k];
		endfunction

		function res_t predict_list_op(cmd_t c);
			res_t                r;
			logic [DefWidth-1:0] v;
			int unsigned         pos;
			r.status         = ST_OK;
			r.found_position = '0;
			v                = c.value[DefWidth-1:0];
			pos              = c.position;
			case (c.op)
				OP_PUSH_BACK: begin
					if (occupancy >= DefDepth) begin
						r.status = ST_FULL;
					end else begin
						entries[occupancy] = v;
						occupancy++;
					end
				end
				OP_PUSH_FRONT: begin
					if (occupancy >= DefDepth) begin
						r.status = ST_FULL;
					end else begin
						open_slot(0);
						entries[0] = v;
						occupancy++;
					end
				end
				OP_POP_BACK: begin
					if (occupancy == 0)
						r.status = ST_EMPTY;
					else
						occupancy--;
				end
				OP_POP_FRONT: begin
					if (occupancy == 0) begin
						r.status = ST_EMPTY;
					end else begin
						close_slot(0);
						occupancy--;
					end
				end
				OP_INSERT: begin
					// full takes precedence over a bad position
					if (occupancy >= DefDepth) begin
						r.status = ST_FULL;
					end else if (pos > occupancy) begin
						r.status = ST_BADPOS;
					end else begin
						open_slot(pos);
						entries[pos] = v;
						occupancy++;
					end
				end
				OP_ERASE: begin
					if (occupancy == 0) begin
						r.status = ST_EMPTY;
					end else if (pos >= occupancy) begin
						r.status = ST_BADPOS;
					end else begin
						close_slot(pos);
						occupancy--;
					end
				end
				OP_FIND: begin
					r.status = ST_NOTFOUND;
					for (int unsigned k = 0; k < occupancy; k++) begin
						if (entries[k] == v) begin
							r.status         = ST_OK;
							r.found_position = PosW'(k + 1);
							break;
						end
					end
				end
				default: begin
				end
			endcase
			r.count = PosW'(occupancy);
			return r;
		endfunction

		function void note_command(cmd_t c);
			expected_results.push_back(predict_list_op(c));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, got status %0d found %0d count %0d",
					$time, got.status, got.found_position, got.count);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0d got %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.found_position !== want.found_position) begin
				$display("%0t: found_position mismatch, expected %0d got %0d",
					$time, want.found_position, got.found_position);
				errors++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count mismatch, expected %0d got %0d",
					$time, want.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic strobe;
	res_t result;

	list_scoreboard sb = new();
	int unsigned    cycles = 0;

	sequential_list_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Check before noting: a strobe at this edge belongs to an earlier beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_result(result);
			if (start && !busy)
				sb.note_command(cmd);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LimitCycles) begin
			$display("sequential_list_engine verification failed");
			$finish;
		end
	end

	// Present one beat at a falling edge and hold it until taken.
	task automatic send_beat(input cmd_t c, input bit may_idle);
		if (may_idle) begin
			while ($urandom_range(0, 99) < IdlePercent) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_op(input logic [2:0] op, input int unsigned pos,
			input logic [31:0] val);
		cmd_t c;
		c.op       = op_t'(op);
		c.position = PosW'(pos);
		c.value    = val;
		send_beat(c, 1'b1);
	endtask

	function automatic cmd_t pick_command(input bit grow);
		cmd_t        c;
		int unsigned r;
		int unsigned n;
		n = sb.occupancy;
		r = $urandom_range(0, 99);
		if (grow) begin
			if (r < 45)      c.op = OP_PUSH_BACK;
			else if (r < 60) c.op = OP_PUSH_FRONT;
			else if (r < 80) c.op = OP_INSERT;
			else if (r < 85) c.op = OP_POP_BACK;
			else if (r < 87) c.op = OP_POP_FRONT;
			else if (r < 89) c.op = OP_ERASE;
			else if (r < 97) c.op = OP_FIND;
			else             c.op = op_t'(OP_UNDEFINED);
		end else begin
			if (r < 6)       c.op = OP_PUSH_BACK;
			else if (r < 9)  c.op = OP_PUSH_FRONT;
			else if (r < 12) c.op = OP_INSERT;
			else if (r < 40) c.op = OP_POP_BACK;
			else if (r < 60) c.op = OP_POP_FRONT;
			else if (r < 85) c.op = OP_ERASE;
			else if (r < 97) c.op = OP_FIND;
			else             c.op = op_t'(OP_UNDEFINED);
		end
		r = $urandom_range(0, 99);
		if (r < 70)
			c.position = PosW'($urandom_range(0, n));
		else if (r < 85)
			c.position = PosW'(n + $urandom_range(0, 1));
		else
			c.position = PosW'($urandom_range(0, 511));
		// favour stored values so that finds hit
		r = $urandom_range(0, 99);
		if (n > 0 && r < 35)
			c.value = sb.entries[$urandom_range(0, n - 1)];
		else if (r < 55)
			c.value = $urandom_range(0, 15) - 8;
		else
			c.value = $urandom;
		return c;
	endfunction

	initial begin
		int i;
		int dwell;
		bit grow;
		start  = 1'b0;
		cmd    = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list corners
		send_op(OP_POP_BACK, 0, 32'h0);
		send_op(OP_POP_FRONT, 0, 32'h0);
		send_op(OP_ERASE, 0, 32'h0);
		send_op(OP_FIND, 0, 32'h0);
		send_op(OP_UNDEFINED, 0, 32'h0);
		send_op(OP_INSERT, 1, 32'h1);
		// build a short list with extreme values
		send_op(OP_INSERT, 0, 32'h8000_0000);
		send_op(OP_PUSH_BACK, 0, 32'h7FFF_FFFF);
		send_op(OP_PUSH_FRONT, 0, 32'hFFFF_FFFF);
		send_op(OP_PUSH_BACK, 0, 32'h0000_0000);
		send_op(OP_INSERT, sb.occupancy, 32'h0000_0005);
		send_op(OP_INSERT, sb.occupancy + 1, 32'h0000_0006);
		send_op(OP_INSERT, 511, 32'hA5A5_A5A5);
		send_op(OP_INSERT, 2, 32'h1234_5678);
		send_op(OP_FIND, 0, 32'h7FFF_FFFF);
		send_op(OP_FIND, 0, 32'hFFFF_FFFF);
		send_op(OP_FIND, 0, 32'hDEAD_BEEF);
		send_op(OP_ERASE, sb.occupancy, 32'h0);
		send_op(OP_ERASE, 511, 32'h0);
		send_op(OP_ERASE, sb.occupancy - 1, 32'h0);
		send_op(OP_ERASE, 0, 32'h0);
		send_op(OP_ERASE, 1, 32'h0);
		send_op(OP_POP_FRONT, 0, 32'h0);
		send_op(OP_POP_BACK, 0, 32'h0);
		send_op(OP_UNDEFINED, 300, 32'h5555_AAAA);

		// grow to full, linger there, then drain to empty and so on
		grow  = 1'b1;
		dwell = 0;
		for (i = 0; i < RandomItems; i++) begin
			if (grow && sb.occupancy == DefDepth) begin
				dwell++;
				if (dwell > 12) begin
					grow  = 1'b0;
					dwell = 0;
				end
			end else if (!grow && sb.occupancy == 0) begin
				dwell++;
				if (dwell > 12) begin
					grow  = 1'b1;
					dwell = 0;
				end
			end
			send_beat(pick_command(grow), !(i >= 250 && i < 400));
		end
		start <= 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DefDepth + 8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("sequential_list_engine verification clean");
		end else begin
			$display("sequential_list_engine verification failed");
		end
		$finish;
	end

endmodule
